[rtl/e2d_pkg.sv]
// ----------------------------------------------------------------------------
// e2d_pkg: shared types and constants for the euler angles to dcm block
// Holds the cordic angle table, axis sequence table and the sequence struct.
// ----------------------------------------------------------------------------
package e2d_pkg;

   localparam int ANGLE_BITS   = 16;
   localparam int FRAC_BITS    = 14;
   localparam int CORDIC_STEPS = 30;
   localparam int CW           = 34;   // cordic x/y width, q2.30 plus guard
   localparam int ZW           = 33;   // cordic angle width
   localparam int EW           = 16;   // element width
   localparam int PW           = 32;   // product width
   localparam int SW           = 34;   // sum-of-products width
   localparam int NUM_SEQ      = 12;

   localparam logic [CW-1:0] CORDIC_GAIN = CW'(652032874);
   localparam logic [3:0]    SEQ_CODE_LIMIT = 4'd12;
   localparam logic [1:0]    AXIS_X = 2'd0;
   localparam logic [1:0]    AXIS_Y = 2'd1;
   localparam logic [1:0]    AXIS_Z = 2'd2;
   localparam logic [0:0]    ADDR_AXIS_SEQUENCE = 1'b0;

   typedef logic signed [EW-1:0] elem_type;
   typedef elem_type mat_type [3][3];

   typedef struct packed {
      logic [1:0] a1;
      logic [1:0] a2;
      logic [1:0] a3;
      logic       ident;
   } seq_type;

   function automatic logic [ZW-1:0] atan_turns(input int i);
      logic [31:0] t;
      begin
         unique case (i)
            0: t = 32'h20000000;  1: t = 32'h12E4051E;  2: t = 32'h09FB385B;
            3: t = 32'h051111D4;  4: t = 32'h028B0D43;  5: t = 32'h0145D7E1;
            6: t = 32'h00A2F61E;  7: t = 32'h00517C55;  8: t = 32'h0028BE53;
            9: t = 32'h00145F2F;  10: t = 32'h000A2F98; 11: t = 32'h000517CC;
            12: t = 32'h00028BE6; 13: t = 32'h000145F3; 14: t = 32'h0000A2FA;
            15: t = 32'h0000517D; 16: t = 32'h000028BE; 17: t = 32'h0000145F;
            18: t = 32'h00000A30; 19: t = 32'h00000518; 20: t = 32'h0000028C;
            21: t = 32'h00000146; 22: t = 32'h000000A3; 23: t = 32'h00000051;
            24: t = 32'h00000029; 25: t = 32'h00000014; 26: t = 32'h0000000A;
            27: t = 32'h00000005; 28: t = 32'h00000003; default: t = 32'h00000001;
         endcase
         atan_turns = {1'b0, t};
      end
   endfunction

   function automatic seq_type seq_lookup(input logic [3:0] code);
      seq_type s;
      begin
         s.ident = 1'b0;
         unique case (code)
            4'd0: begin  s.a1 = AXIS_X; s.a2 = AXIS_Y; s.a3 = AXIS_Z; end
            4'd1: begin  s.a1 = AXIS_Z; s.a2 = AXIS_X; s.a3 = AXIS_Z; end
            4'd2: begin  s.a1 = AXIS_X; s.a2 = AXIS_Y; s.a3 = AXIS_X; end
            4'd3: begin  s.a1 = AXIS_Y; s.a2 = AXIS_Z; s.a3 = AXIS_Y; end
            4'd4: begin  s.a1 = AXIS_Z; s.a2 = AXIS_Y; s.a3 = AXIS_Z; end
            4'd5: begin  s.a1 = AXIS_X; s.a2 = AXIS_Z; s.a3 = AXIS_X; end
            4'd6: begin  s.a1 = AXIS_Y; s.a2 = AXIS_X; s.a3 = AXIS_Y; end
            4'd7: begin  s.a1 = AXIS_Y; s.a2 = AXIS_Z; s.a3 = AXIS_X; end
            4'd8: begin  s.a1 = AXIS_Z; s.a2 = AXIS_X; s.a3 = AXIS_Y; end
            4'd9: begin  s.a1 = AXIS_X; s.a2 = AXIS_Z; s.a3 = AXIS_Y; end
            4'd10: begin s.a1 = AXIS_Z; s.a2 = AXIS_Y; s.a3 = AXIS_X; end
            4'd11: begin s.a1 = AXIS_Y; s.a2 = AXIS_X; s.a3 = AXIS_Z; end
            default: begin
               s.a1 = AXIS_X; s.a2 = AXIS_X; s.a3 = AXIS_X; s.ident = 1'b1;
            end
         endcase
         seq_lookup = s;
      end
   endfunction

   // round a wide value by dropping sh bits (add half, floor), saturate to +-1
   function automatic elem_type round_sat(input logic signed [SW-1:0] v, input int sh);
      logic signed [SW:0] r;
      logic signed [SW:0] one;
      begin
         one = (SW+1)'(1) <<< FRAC_BITS;
         r = ($signed({v[SW-1], v}) + ((SW+1)'(1) <<< (sh-1))) >>> sh;
         if (r > one) r = one;
         if (r < -one) r = -one;
         round_sat = r[EW-1:0];
      end
   endfunction

endpackage

[rtl/e2d_cordic.sv]
// ----------------------------------------------------------------------------
// e2d_cordic: pipelined sine/cosine of one binary angle
// Quarter-turn reduction then one registered cordic step per stage.
// ----------------------------------------------------------------------------
module e2d_cordic (
   input  logic                               clock,
   input  logic                               advance,
   input  logic [e2d_pkg::ANGLE_BITS-1:0]     angle,
   output e2d_pkg::elem_type                  cos_out,
   output e2d_pkg::elem_type                  sin_out
);
   localparam int N = e2d_pkg::CORDIC_STEPS;
   localparam int CW = e2d_pkg::CW;
   localparam int ZW = e2d_pkg::ZW;

   logic signed [CW-1:0] x_ff [N+1];
   logic signed [CW-1:0] y_ff [N+1];
   logic signed [ZW-1:0] z_ff [N+1];
   logic [1:0]           q_ff [N+1];
   e2d_pkg::elem_type    cos_ff, sin_ff;

   logic [31:0] a_full;
   logic [1:0]  q_in;
   logic [31:0] ru;

   always_comb begin
      a_full = {angle, {(32-e2d_pkg::ANGLE_BITS){1'b0}}};
      q_in   = 2'((a_full + 32'h20000000) >> 30);
      ru     = a_full - {q_in, 30'd0};
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         x_ff[0] <= $signed(e2d_pkg::CORDIC_GAIN);
         y_ff[0] <= '0;
         z_ff[0] <= $signed({ru[31], ru});
         q_ff[0] <= q_in;
      end
   end

   for (genvar i = 0; i < N; i++) begin : g_step
      logic signed [CW-1:0] x_in, y_in;
      logic signed [ZW-1:0] z_in;
      always_comb begin
         if (!z_ff[i][ZW-1]) begin
            x_in = x_ff[i] - (y_ff[i] >>> i);
            y_in = y_ff[i] + (x_ff[i] >>> i);
            z_in = z_ff[i] - $signed(e2d_pkg::atan_turns(i));
         end else begin
            x_in = x_ff[i] + (y_ff[i] >>> i);
            y_in = y_ff[i] - (x_ff[i] >>> i);
            z_in = z_ff[i] + $signed(e2d_pkg::atan_turns(i));
         end
      end
      always_ff @(posedge clock) begin
         if (advance) begin
            x_ff[i+1] <= x_in;
            y_ff[i+1] <= y_in;
            z_ff[i+1] <= z_in;
            q_ff[i+1] <= q_ff[i];
         end
      end
   end

   e2d_pkg::elem_type c_in, s_in, cos_in, sin_in;
   always_comb begin
      c_in = e2d_pkg::round_sat(x_ff[N], 30 - e2d_pkg::FRAC_BITS);
      s_in = e2d_pkg::round_sat(y_ff[N], 30 - e2d_pkg::FRAC_BITS);
      unique case (q_ff[N])
         2'd0: begin cos_in = c_in;  sin_in = s_in;  end
         2'd1: begin cos_in = -s_in; sin_in = c_in;  end
         2'd2: begin cos_in = -c_in; sin_in = -s_in; end
         default: begin cos_in = s_in; sin_in = -c_in; end
      endcase
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         cos_ff <= cos_in;
         sin_ff <= sin_in;
      end
   end

   assign cos_out = cos_ff;
   assign sin_out = sin_ff;
endmodule

[rtl/e2d_matmul.sv]
// ----------------------------------------------------------------------------
// e2d_matmul: two-stage 3x3 fixed-point matrix product
// Products registered, then summed, rounded and saturated.
// ----------------------------------------------------------------------------
module e2d_matmul (
   input  logic               clock,
   input  logic               advance,
   input  e2d_pkg::mat_type   a,
   input  e2d_pkg::mat_type   b,
   output e2d_pkg::mat_type   p
);
   logic signed [e2d_pkg::PW-1:0] prod_ff [3][3][3];
   e2d_pkg::mat_type              p_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int r = 0; r < 3; r++)
            for (int k = 0; k < 3; k++)
               for (int j = 0; j < 3; j++)
                  prod_ff[r][k][j] <= a[r][j] * b[j][k];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int r = 0; r < 3; r++)
            for (int k = 0; k < 3; k++)
               p_ff[r][k] <= e2d_pkg::round_sat(
                  e2d_pkg::SW'(prod_ff[r][k][0]) + e2d_pkg::SW'(prod_ff[r][k][1])
                  + e2d_pkg::SW'(prod_ff[r][k][2]), e2d_pkg::FRAC_BITS);
      end
   end

   assign p = p_ff;
endmodule

[rtl/euler_angles_to_dcm_top.sv]
// ----------------------------------------------------------------------------
// euler_angles_to_dcm_top: euler angles to direction cosine matrix
// Three cordic pipelines feed two pipelined 3x3 products.
// ----------------------------------------------------------------------------
// One item per cycle is accepted while the pipe advances; the item is loaded
// into the reduction stage at the accepting edge, then passes 30 cordic steps,
// one rounding stage, one rotation-build stage, two stages per matrix product
// and the output register, where its matrix is presented. The whole pipe
// advances when the output register is empty or being taken, so a stall
// freezes every stage. The sequence code is sampled with each item.
module euler_angles_to_dcm_top (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [47:0]  req_tdata,   // first_angle, second_angle, third_angle
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [143:0] rsp_tdata,   // c11 c12 c13 c21 c22 c23 c31 c32 c33
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [0:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);
   localparam int LAT = 37;   // stages before output register
   localparam int CL  = e2d_pkg::CORDIC_STEPS + 2;

   logic [3:0] seq_ff;
   logic       advance;
   logic [LAT-1:0] vld_ff;
   e2d_pkg::seq_type sq_ff [CL];
   logic       out_vld_ff;
   logic [143:0] out_ff;

   assign csr_pready = 1'b1;
   assign csr_prdata = {28'd0, seq_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite
                   && csr_paddr == e2d_pkg::ADDR_AXIS_SEQUENCE) begin
         seq_ff <= csr_pwdata[3:0];
      end
   end

   assign advance    = !out_vld_ff || rsp_tready;
   assign req_tready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[LAT-2:0], req_tvalid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sq_ff[0] <= e2d_pkg::seq_lookup(seq_ff);
         for (int i = 1; i < CL; i++) sq_ff[i] <= sq_ff[i-1];
      end
   end

   e2d_pkg::elem_type cs [3];
   e2d_pkg::elem_type sn [3];
   for (genvar g = 0; g < 3; g++) begin : g_trig
      e2d_cordic u_cordic (
         .clock(clock), .advance(advance),
         .angle(req_tdata[16*g +: 16]),
         .cos_out(cs[g]), .sin_out(sn[g])
      );
   end

   // build the three rotation matrices; identity code uses plain identity
   e2d_pkg::mat_type r_in [3];
   e2d_pkg::mat_type r_ff [3];
   logic [1:0] ax [3];
   always_comb begin
      logic [1:0] ia, ja;
      ax[0] = sq_ff[CL-1].a1;
      ax[1] = sq_ff[CL-1].a2;
      ax[2] = sq_ff[CL-1].a3;
      for (int m = 0; m < 3; m++) begin
         ia = (ax[m] == e2d_pkg::AXIS_Z) ? e2d_pkg::AXIS_X : ax[m] + 2'd1;
         ja = (ia == e2d_pkg::AXIS_Z) ? e2d_pkg::AXIS_X : ia + 2'd1;
         for (int r = 0; r < 3; r++)
            for (int k = 0; k < 3; k++)
               r_in[m][r][k] = (r == k) ? e2d_pkg::elem_type'(1 << e2d_pkg::FRAC_BITS) : '0;
         if (!sq_ff[CL-1].ident) begin
            r_in[m][ia][ia] = cs[m];
            r_in[m][ja][ja] = cs[m];
            r_in[m][ia][ja] = sn[m];
            r_in[m][ja][ia] = -sn[m];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         r_ff <= r_in;
      end
   end

   e2d_pkg::mat_type t_mat, m_mat, r3_d;
   e2d_matmul u_mul1 (.clock(clock), .advance(advance),
                      .a(r_ff[0]), .b(r_ff[1]), .p(t_mat));

   // third rotation waits two stages for the first product
   e2d_pkg::mat_type r3_ff [2];
   always_ff @(posedge clock) begin
      if (advance) begin
         r3_ff[0] <= r_ff[2];
         r3_ff[1] <= r3_ff[0];
      end
   end
   assign r3_d = r3_ff[1];

   e2d_matmul u_mul2 (.clock(clock), .advance(advance),
                      .a(t_mat), .b(r3_d), .p(m_mat));

   logic [143:0] out_in;
   always_comb begin
      for (int r = 0; r < 3; r++)
         for (int k = 0; k < 3; k++)
            out_in[16*(3*r+k) +: 16] = m_mat[r][k];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (advance) begin
         out_vld_ff <= vld_ff[LAT-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) out_ff <= out_in;
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_ff;

   // a stalled result holds its data
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed during stall");

   // input is taken whenever the output side is free
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input blocked with empty output");

   // first element never exceeds one in magnitude
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($signed(rsp_tdata[15:0]) <= 16384
                      && $signed(rsp_tdata[15:0]) >= -16384))
      else $error("element out of range");
endmodule
